@@ sv/ufs_pkg.sv @@
// Shared constants, register codes and structs of the uncore frequency steering block.
// Depends on nothing; every other file refers to it by scoped names.
package ufs_pkg;

    // Sizing
    localparam int NUM_PACKAGES = 8;
    localparam int TABLE_DEPTH  = 4;
    localparam int PKG_IDX_W    = (NUM_PACKAGES > 1) ? $clog2(NUM_PACKAGES) : 1;
    localparam int TIDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths
    localparam int PKG_W      = 3;
    localparam int MHZ_W      = 16;
    localparam int RATE_W     = 32;
    localparam int CNT32_W    = 32;
    localparam int PHI_W      = 11;
    localparam int USED_W     = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    // Serial multiply and divide sizes
    localparam int MAG_W   = MHZ_W;           // multiplier bits, one per cycle
    localparam int QUO_W   = MHZ_W + 1;       // quotient bits kept, one per cycle
    localparam int PROD_W  = MAG_W + RATE_W;
    localparam int STEP_W  = 5;

    // Bias constants, Q10
    localparam logic [PHI_W-1:0] PHI_HALF = 11'd512;
    localparam logic [PHI_W-1:0] PHI_ONE  = 11'd1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_PHI   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNCORE_MAX = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNCORE_EFF = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_USED = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BW_ENTRY_A = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BW_ENTRY_B = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BW_ENTRY_C = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BW_ENTRY_D = 4'd7;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [PHI_W-1:0]                    phi;
        logic [MHZ_W-1:0]                    fmax;
        logic [MHZ_W-1:0]                    feff;
        logic [USED_W-1:0]                   used;
        logic [TABLE_DEPTH-1:0][MHZ_W-1:0]   key;
        logic [TABLE_DEPTH-1:0][RATE_W-1:0]  limit;
    } cfg_t;

    // Resolved range and chosen limit for one item
    typedef struct packed {
        logic [MHZ_W-1:0]  rmax;
        logic [MHZ_W-1:0]  reff;
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [RATE_W-1:0] limit;
        logic              ratio_one;
    } front_t;

    // Serial divider result
    typedef struct packed {
        logic             sat;
        logic [QUO_W-1:0] quo;
    } quot_t;

endpackage

@@ sv/ufs_meas_if.sv @@
// Measurement channel: one package sample per item.
// Depends on ufs_pkg for field widths.
interface ufs_meas_if;
    logic                       valid;
    logic                       ready;
    logic [ufs_pkg::PKG_W-1:0]  package_id;
    logic [ufs_pkg::MHZ_W-1:0]  status_mhz;
    logic                       status_ok;
    logic [ufs_pkg::RATE_W-1:0] bw_rate;
    logic                       bw_rate_ok;

    modport source (output valid, package_id, status_mhz, status_ok, bw_rate, bw_rate_ok,
                    input ready);
    modport sink   (input valid, package_id, status_mhz, status_ok, bw_rate, bw_rate_ok,
                    output ready);
endinterface

@@ sv/ufs_steer_if.sv @@
// Result channel: one frequency request per item.
// Depends on ufs_pkg for field widths.
interface ufs_steer_if;
    logic                        valid;
    logic                        ready;
    logic [ufs_pkg::PKG_W-1:0]   package_out;
    logic [ufs_pkg::MHZ_W-1:0]   request_mhz;
    logic                        was_clamped;
    logic                        write_needed;
    logic [ufs_pkg::CNT32_W-1:0] request_total;
    logic [ufs_pkg::CNT32_W-1:0] clamp_total;

    modport source (output valid, package_out, request_mhz, was_clamped, write_needed,
                    request_total, clamp_total, input ready);
    modport sink   (input valid, package_out, request_mhz, was_clamped, write_needed,
                    request_total, clamp_total, output ready);
endinterface

@@ sv/ufs_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on ufs_pkg for widths.
interface ufs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ufs_pkg::CFG_IDX_W-1:0]  index;
    logic [ufs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/ufs_cfg_regs.sv @@
// Configuration register file of the steering block.
// Depends on ufs_pkg and ufs_cfg_if.
module ufs_cfg_regs
(
    input  logic           clk,
    input  logic           rst_n,
    ufs_cfg_if.sink        cfg,
    output ufs_pkg::cfg_t  regs
);

    // Register contents after reset
    localparam ufs_pkg::cfg_t CFG_RESET = '{phi:   ufs_pkg::PHI_HALF,
                                            fmax:  16'd2400,
                                            feff:  16'd1200,
                                            used:  3'd1,
                                            key:   '0,
                                            limit: '0};

    ufs_pkg::cfg_t regs_reg;
    ufs_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the write
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                ufs_pkg::REG_BIAS_PHI:   regs_next.phi  = cfg.data[ufs_pkg::PHI_W-1:0];
                ufs_pkg::REG_UNCORE_MAX: regs_next.fmax = cfg.data[ufs_pkg::MHZ_W-1:0];
                ufs_pkg::REG_UNCORE_EFF: regs_next.feff = cfg.data[ufs_pkg::MHZ_W-1:0];
                ufs_pkg::REG_TABLE_USED: regs_next.used = cfg.data[ufs_pkg::USED_W-1:0];
                ufs_pkg::REG_BW_ENTRY_A,
                ufs_pkg::REG_BW_ENTRY_B,
                ufs_pkg::REG_BW_ENTRY_C,
                ufs_pkg::REG_BW_ENTRY_D:
                begin
                    for (int k = 0; k < ufs_pkg::TABLE_DEPTH; k++)
                    begin
                        if (cfg.index == ufs_pkg::REG_BW_ENTRY_A
                                         + ufs_pkg::CFG_IDX_W'(k))
                        begin
                            regs_next.key[k]   = cfg.data[47:32];
                            regs_next.limit[k] = cfg.data[31:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ sv/ufs_front.sv @@
// Front end: table lookup and bias range resolution, two register stages.
// Depends on ufs_pkg.
module ufs_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  ufs_pkg::cfg_t              regs,
    input  logic [ufs_pkg::MHZ_W-1:0]  freq,
    input  logic                       freq_ok,
    input  logic                       rate_ok,
    output logic                       done,
    output ufs_pkg::front_t            res
);

    logic                              s1_vld_reg;
    logic signed [27:0]                prod_reg;
    logic                              up_reg;
    logic                              dn_reg;
    logic [ufs_pkg::RATE_W-1:0]        limit_reg;
    logic                              rate_ok_reg;
    logic                              done_reg;
    ufs_pkg::front_t                   res_reg;

    logic [ufs_pkg::PHI_W-1:0]         phi_c;
    logic signed [16:0]                r0;
    logic [9:0]                        dval;
    logic signed [27:0]                prod_next;
    logic [ufs_pkg::USED_W-1:0]        n_eff;
    logic [ufs_pkg::TIDX_W-1:0]        best;
    logic [ufs_pkg::TIDX_W-1:0]        low;
    logic [ufs_pkg::TIDX_W-1:0]        high;
    logic                              best_ok;
    logic [ufs_pkg::TIDX_W-1:0]        pick;

    logic signed [27:0]                shr;
    logic signed [19:0]                quo;
    logic signed [19:0]                fmax20;
    logic signed [19:0]                feff20;
    logic signed [19:0]                t_up;
    logic signed [19:0]                t_dn;
    logic [ufs_pkg::MHZ_W-1:0]         rmax;
    logic [ufs_pkg::MHZ_W-1:0]         reff;
    logic signed [16:0]                span;
    ufs_pkg::front_t                   res_next;

    // Stage one: clamp the bias and form the scaled range
    always_comb
    begin
        phi_c = (regs.phi > ufs_pkg::PHI_ONE) ? ufs_pkg::PHI_ONE : regs.phi;
        r0    = $signed({1'b0, regs.fmax}) - $signed({1'b0, regs.feff});
        dval  = (phi_c > ufs_pkg::PHI_HALF) ? 10'(phi_c - ufs_pkg::PHI_HALF)
                                            : 10'(ufs_pkg::PHI_HALF - phi_c);
        prod_next = r0 * $signed({1'b0, dval});
    end

    // Stage one: choose the table entry
    always_comb
    begin
        if (regs.used == '0)
            n_eff = 3'd1;
        else if (int'(regs.used) > ufs_pkg::TABLE_DEPTH)
            n_eff = ufs_pkg::USED_W'(ufs_pkg::TABLE_DEPTH);
        else
            n_eff = regs.used;
        best    = '0;
        low     = '0;
        high    = '0;
        best_ok = 1'b0;
        for (int i = 0; i < ufs_pkg::TABLE_DEPTH; i++)
        begin
            if (i < int'(n_eff))
            begin
                if (regs.key[i] < regs.key[low])
                    low = ufs_pkg::TIDX_W'(i);
                if (regs.key[i] > regs.key[high])
                    high = ufs_pkg::TIDX_W'(i);
                if (regs.key[i] <= freq && (!best_ok || regs.key[i] > regs.key[best]))
                begin
                    best    = ufs_pkg::TIDX_W'(i);
                    best_ok = 1'b1;
                end
            end
        end
        if (!freq_ok)
            pick = high;
        else if (!best_ok)
            pick = low;
        else
            pick = best;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg    <= prod_next;
            up_reg      <= (phi_c > ufs_pkg::PHI_HALF);
            dn_reg      <= (phi_c < ufs_pkg::PHI_HALF);
            limit_reg   <= regs.limit[pick];
            rate_ok_reg <= rate_ok;
        end
    end

    // Stage two: divide by 512 toward zero and resolve the range
    always_comb
    begin
        shr    = prod_reg >>> 9;
        quo    = $signed({shr[18], shr[18:0]})
               + $signed({19'b0, (prod_reg[27] && (prod_reg[8:0] != '0))});
        fmax20 = $signed({4'b0, regs.fmax});
        feff20 = $signed({4'b0, regs.feff});
        t_up   = fmax20 - quo;
        t_dn   = feff20 + quo;
        rmax   = regs.fmax;
        reff   = regs.feff;
        if (up_reg)
            rmax = (t_up > feff20) ? t_up[15:0] : regs.feff;
        if (dn_reg)
            reff = (t_dn < fmax20) ? t_dn[15:0] : regs.fmax;
        span = $signed({1'b0, rmax}) - $signed({1'b0, reff});
        res_next.rmax      = rmax;
        res_next.reff      = reff;
        res_next.neg       = span[16];
        res_next.mag       = span[16] ? 16'(-span) : span[15:0];
        res_next.limit     = limit_reg;
        res_next.ratio_one = !rate_ok_reg || (limit_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
            res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ sv/ufs_muldiv.sv @@
// Bit-serial multiply of range by rate, then bit-serial restoring divide by the limit.
// Depends on ufs_pkg. Quotients of 2^17 and above are flagged as saturated.
module ufs_muldiv
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ufs_pkg::MAG_W-1:0]   mag,
    input  logic [ufs_pkg::RATE_W-1:0]  mult,
    input  logic [ufs_pkg::RATE_W-1:0]  divisor,
    output logic                        done,
    output ufs_pkg::quot_t              quot
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_CHK  = 2'd2;
    localparam logic [1:0] PH_DIV  = 2'd3;

    logic [1:0]                        phase_reg;
    logic [1:0]                        phase_next;
    logic [ufs_pkg::STEP_W-1:0]        step_reg;
    logic [ufs_pkg::STEP_W-1:0]        step_next;
    logic                              done_reg;
    logic                              done_next;
    logic                              sat_reg;
    logic                              sat_next;
    logic [ufs_pkg::PROD_W-1:0]        prod_reg;
    logic [ufs_pkg::PROD_W-1:0]        prod_next;
    logic [ufs_pkg::RATE_W-1:0]        mult_reg;
    logic [ufs_pkg::RATE_W-1:0]        div_reg;
    logic [ufs_pkg::RATE_W-1:0]        rem_reg;
    logic [ufs_pkg::RATE_W-1:0]        rem_next;
    logic [ufs_pkg::QUO_W-1:0]         sh_reg;
    logic [ufs_pkg::QUO_W-1:0]         sh_next;

    logic [ufs_pkg::RATE_W:0]          psum;
    logic [ufs_pkg::RATE_W:0]          trial;
    logic [ufs_pkg::RATE_W:0]          tdiff;
    logic                              ge;

    // One multiply or divide step
    always_comb
    begin
        psum  = {1'b0, prod_reg[ufs_pkg::PROD_W-1:ufs_pkg::MAG_W]}
              + (prod_reg[0] ? {1'b0, mult_reg} : '0);
        trial = {rem_reg, sh_reg[ufs_pkg::QUO_W-1]};
        tdiff = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});
    end

    // Sequence the phases
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    prod_next  = {{ufs_pkg::RATE_W{1'b0}}, mag};
                    step_next  = ufs_pkg::STEP_W'(ufs_pkg::MAG_W - 1);
                    phase_next = PH_MUL;
                end
            end
            PH_MUL:
            begin
                prod_next = {psum, prod_reg[ufs_pkg::MAG_W-1:1]};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    phase_next = PH_CHK;
            end
            PH_CHK:
            begin
                // High part at or above the divisor means a quotient past 17 bits
                sat_next = ({1'b0, prod_reg[ufs_pkg::PROD_W-1:ufs_pkg::QUO_W]} >= div_reg);
                rem_next = {1'b0, prod_reg[ufs_pkg::PROD_W-1:ufs_pkg::QUO_W]};
                sh_next  = prod_reg[ufs_pkg::QUO_W-1:0];
                step_next = ufs_pkg::STEP_W'(ufs_pkg::QUO_W - 1);
                if (sat_next)
                begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_DIV;
                end
            end
            PH_DIV:
            begin
                rem_next  = ge ? tdiff[ufs_pkg::RATE_W-1:0] : trial[ufs_pkg::RATE_W-1:0];
                sh_next   = {sh_reg[ufs_pkg::QUO_W-2:0], ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        sat_reg  <= sat_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        if (start && phase_reg == PH_IDLE)
        begin
            mult_reg <= mult;
            div_reg  <= divisor;
        end
    end

    assign done     = done_reg;
    assign quot.sat = sat_reg;
    assign quot.quo = sh_reg;

    // Assertions
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> phase_reg == PH_IDLE)
        else $error("serial unit started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> phase_reg == PH_IDLE)
        else $error("serial unit done while still stepping");
    a_div_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DIV |-> rem_reg < div_reg)
        else $error("partial remainder not below divisor");

endmodule

@@ sv/ufs_track.sv @@
// Per-package setting store with write and clamp counters.
// Depends on ufs_pkg.
module ufs_track
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         commit,
    input  logic [ufs_pkg::PKG_W-1:0]    pkg,
    input  logic [ufs_pkg::MHZ_W-1:0]    req,
    input  logic                         clamped,
    output logic                         write_needed,
    output logic [ufs_pkg::CNT32_W-1:0]  request_total,
    output logic [ufs_pkg::CNT32_W-1:0]  clamp_total
);

    logic [ufs_pkg::MHZ_W-1:0]          last_setting_reg [ufs_pkg::NUM_PACKAGES];
    logic [ufs_pkg::NUM_PACKAGES-1:0]   known_reg;
    logic [ufs_pkg::CNT32_W-1:0]        write_cnt_reg;
    logic [ufs_pkg::CNT32_W-1:0]        clamp_cnt_reg;

    logic [ufs_pkg::PKG_IDX_W-1:0]      idx;
    logic                               in_range;

    // Compare against the stored setting and form the totals after this item
    always_comb
    begin
        idx          = ufs_pkg::PKG_IDX_W'(pkg);
        in_range     = (int'(pkg) < ufs_pkg::NUM_PACKAGES);
        write_needed = in_range && (!known_reg[idx] || last_setting_reg[idx] != req);
        request_total = (write_needed && write_cnt_reg != '1) ? write_cnt_reg + 1'b1
                                                              : write_cnt_reg;
        clamp_total   = (clamped && clamp_cnt_reg != '1) ? clamp_cnt_reg + 1'b1
                                                         : clamp_cnt_reg;
    end

    // Advance counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg     <= '0;
            write_cnt_reg <= '0;
            clamp_cnt_reg <= '0;
        end
        else if (commit)
        begin
            write_cnt_reg <= request_total;
            clamp_cnt_reg <= clamp_total;
            if (write_needed)
                known_reg[idx] <= 1'b1;
        end
    end

    // Store the new setting
    always_ff @(posedge clk)
    begin
        if (commit && write_needed)
            last_setting_reg[idx] <= req;
    end

endmodule

@@ sv/uncore_frequency_steering_top.sv @@
// Uncore frequency steering: one measurement in, one frequency request out.
//
// Channels: meas takes one package sample per item (valid/ready); steer gives
// one request per item (valid/ready); cfg writes one register per handshake
// and is always ready. Write cfg only while no item is in flight.
// Flow: an item is taken only when the block is idle. The front end registers
// the table lookup and then the range resolution. Unless the ratio is taken
// as one or the range is negative, a bit-serial unit then does the multiply
// (one range bit per cycle), an overflow check and, if no overflow is found,
// the restoring divide (one quotient bit per cycle). The quotient is then
// handed back and the result committed. The block takes one item at a time:
// a new sample is taken only once the last one has been committed.
// A finished result waits in the output register; the next item is taken
// while it waits, and a second result stalls only at commit until steer
// takes the first.
// Reset: registers return to bias 512, ceiling 2400 MHz, efficient point
// 1200 MHz, one table entry of zero; all package settings are forgotten
// and both counters clear.
// Depends on ufs_pkg, the three channel interfaces and all ufs_ modules.
module uncore_frequency_steering_top
(
    input  logic       clk,
    input  logic       rst_n,
    ufs_meas_if.sink   meas,
    ufs_steer_if.source steer,
    ufs_cfg_if.sink    cfg
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FRONT  = 2'd1;
    localparam logic [1:0] ST_MULDIV = 2'd2;
    localparam logic [1:0] ST_FIN    = 2'd3;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;

    logic [ufs_pkg::PKG_W-1:0]         pkg_reg;
    logic [ufs_pkg::RATE_W-1:0]        rate_reg;

    logic                              out_vld_reg;
    logic [ufs_pkg::PKG_W-1:0]         out_pkg_reg;
    logic [ufs_pkg::MHZ_W-1:0]         out_req_reg;
    logic                              out_clamp_reg;
    logic                              out_write_reg;
    logic [ufs_pkg::CNT32_W-1:0]       out_wtot_reg;
    logic [ufs_pkg::CNT32_W-1:0]       out_ctot_reg;

    ufs_pkg::cfg_t                     regs;
    ufs_pkg::front_t                   front;
    ufs_pkg::quot_t                    quot;
    logic                              front_done;
    logic                              md_start;
    logic                              md_done;
    logic                              in_fire;
    logic                              commit;
    logic                              fin_clamped;
    logic [ufs_pkg::MHZ_W-1:0]         fin_req;
    logic                              over;
    logic                              write_needed;
    logic [ufs_pkg::CNT32_W-1:0]       request_total;
    logic [ufs_pkg::CNT32_W-1:0]       clamp_total;

    ufs_cfg_regs u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ufs_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_fire),
        .regs    (regs),
        .freq    (meas.status_mhz),
        .freq_ok (meas.status_ok),
        .rate_ok (meas.bw_rate_ok),
        .done    (front_done),
        .res     (front)
    );

    ufs_muldiv u_muldiv
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (md_start),
        .mag     (front.mag),
        .mult    (rate_reg),
        .divisor (front.limit),
        .done    (md_done),
        .quot    (quot)
    );

    ufs_track u_track
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .commit        (commit),
        .pkg           (pkg_reg),
        .req           (fin_req),
        .clamped       (fin_clamped),
        .write_needed  (write_needed),
        .request_total (request_total),
        .clamp_total   (clamp_total)
    );

    assign meas.ready = (state_reg == ST_IDLE);
    assign in_fire    = meas.valid && meas.ready;
    assign md_start   = (state_reg == ST_FRONT) && front_done
                        && !front.ratio_one && !front.neg;
    assign commit     = (state_reg == ST_FIN) && (!out_vld_reg || steer.ready);

    // Clamp the quotient into the resolved range
    always_comb
    begin
        over = quot.sat || (quot.quo > {1'b0, front.mag});
        if (front.neg)
        begin
            fin_clamped = 1'b1;
            fin_req     = front.rmax;
        end
        else if (front.ratio_one)
        begin
            fin_clamped = 1'b0;
            fin_req     = front.rmax;
        end
        else
        begin
            fin_clamped = over;
            fin_req     = over ? front.rmax : front.reff + quot.quo[ufs_pkg::MHZ_W-1:0];
        end
    end

    // Sequence one item
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_FRONT;
            ST_FRONT:
            begin
                if (front_done)
                    state_next = md_start ? ST_MULDIV : ST_FIN;
            end
            ST_MULDIV: if (md_done) state_next = ST_FIN;
            ST_FIN:    if (commit) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
                out_vld_reg <= 1'b1;
            else if (steer.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Hold the item and the result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pkg_reg  <= meas.package_id;
            rate_reg <= meas.bw_rate;
        end
        if (commit)
        begin
            out_pkg_reg   <= pkg_reg;
            out_req_reg   <= fin_req;
            out_clamp_reg <= fin_clamped;
            out_write_reg <= write_needed;
            out_wtot_reg  <= request_total;
            out_ctot_reg  <= clamp_total;
        end
    end

    assign steer.valid         = out_vld_reg;
    assign steer.package_out   = out_pkg_reg;
    assign steer.request_mhz   = out_req_reg;
    assign steer.was_clamped   = out_clamp_reg;
    assign steer.write_needed  = out_write_reg;
    assign steer.request_total = out_wtot_reg;
    assign steer.clamp_total   = out_ctot_reg;

    // Assertions
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!out_vld_reg || steer.ready))
        else $error("result committed over a waiting item");
    a_req_range: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !front.neg) |-> (fin_req >= front.reff && fin_req <= front.rmax))
        else $error("request outside resolved range");
    a_take_front: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_FRONT))
        else $error("front end not started after an item was taken");
    a_md_owner: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == ST_MULDIV))
        else $error("serial unit finished outside its phase");

endmodule
